FILE: design/rgb_to_hsv_converter_macros.svh
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RHC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence, both written as sequences.
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/rhc_pkg.sv
package rhc_pkg;

  localparam int CH_W    = 8;
  localparam int HUE_W   = 12;
  localparam int QUO_W   = HUE_W + 1;
  localparam int MAG_W   = CH_W + 3;
  localparam int REM_W   = MAG_W + HUE_W;
  localparam int LATENCY = QUO_W + 1;
  localparam int HUE_GREY = ((1 << HUE_W) * 2) / 3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rhc_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
  } rhc_hsv_t;

  typedef struct packed {
    logic [REM_W-1:0] hue_rem;
    logic [REM_W-1:0] hue_div;
    logic [QUO_W-1:0] hue_quo;
    logic [REM_W-1:0] sat_rem;
    logic [REM_W-1:0] sat_div;
    logic [QUO_W-1:0] sat_quo;
    logic [CH_W-1:0]  brightness;
  } rhc_cell_t;

endpackage

FILE: design/rgb_to_hsv_converter.sv
// Pipeline: a pixel accepted at one clock edge shows on out_result for one cycle,
//   with out_valid high, after one sort stage plus 13 divider cells.
// Throughput: one pixel per cycle; busy is always low and start may stay high.
// Reset: synchronous, active low; clears every stage's valid bit, drops in-flight pixels.
// The receiver cannot stall: each result beat is presented for exactly one cycle.
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  rhc_pixel_t in_pixel,
  output logic       out_valid,
  output rhc_hsv_t   out_result
);

  // Stage valid bits and payloads of the chain; index 0 is the sort stage,
  // index k the k-th division cell.
  logic      vld [0:QUO_W];
  rhc_cell_t dat [0:QUO_W];

  // The pipeline never stalls, so every start is taken as a beat.
  assign busy = 1'b0;

  // Sort the channels, form the hue and saturation numerators and both divisors, and
  // register them as the first beat of the chain.
  rhc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (start),
    .pix       (in_pixel),
    .dn_valid  (vld[0]),
    .dn_data   (dat[0])
  );

  // Row of restoring-division cells; each cell resolves one quotient bit of
  // both the hue and the saturation division and hands the beat onward.
  for (genvar gi = 0; gi < QUO_W; gi++) begin : g_cell
    rhc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[gi]),
      .up_data  (dat[gi]),
      .dn_valid (vld[gi+1]),
      .dn_data  (dat[gi+1])
    );
  end

  // Drive the result straight from the last cell's registers. A hue of one
  // full turn wraps to zero by dropping the top quotient bit; saturation
  // never exceeds the channel range.
  assign out_valid             = vld[QUO_W];
  assign out_result.hue        = dat[QUO_W].hue_quo[HUE_W-1:0];
  assign out_result.saturation = dat[QUO_W].sat_quo[CH_W-1:0];
  assign out_result.brightness = dat[QUO_W].brightness;

endmodule

FILE: design/rhc_cell.sv
module rhc_cell import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  rhc_cell_t up_data,
  output logic      dn_valid,
  output rhc_cell_t dn_data
);

  logic      valid_r;
  rhc_cell_t data_r;
  rhc_cell_t data_nxt;
  logic      hue_ge;
  logic      sat_ge;

  // One restoring step for each lane: subtract if it fits, shift in the bit.
  always_comb begin
    hue_ge = (up_data.hue_rem >= up_data.hue_div);
    sat_ge = (up_data.sat_rem >= up_data.sat_div);
    data_nxt = up_data;
    data_nxt.hue_rem = hue_ge ? (up_data.hue_rem - up_data.hue_div) : up_data.hue_rem;
    data_nxt.sat_rem = sat_ge ? (up_data.sat_rem - up_data.sat_div) : up_data.sat_rem;
    data_nxt.hue_quo = {up_data.hue_quo[QUO_W-2:0], hue_ge};
    data_nxt.sat_quo = {up_data.sat_quo[QUO_W-2:0], sat_ge};
    data_nxt.hue_div = up_data.hue_div >> 1;
    data_nxt.sat_div = up_data.sat_div >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: design/rhc_prep.sv
module rhc_prep import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pix_valid,
  input  rhc_pixel_t pix,
  output logic       dn_valid,
  output rhc_cell_t  dn_data
);

  logic               valid_r;
  rhc_cell_t          data_r;
  rhc_cell_t          data_nxt;
  logic               b_lt_g;
  logic               px_lt_r;
  logic [CH_W-1:0]    px;
  logic [CH_W-1:0]    py;
  logic [CH_W-1:0]    qx;
  logic [CH_W-1:0]    qw;
  logic [CH_W-1:0]    lo;
  logic [CH_W-1:0]    d;
  logic [CH_W-1:0]    sat_den;
  logic [MAG_W-1:0]   d_ext;
  logic [MAG_W-1:0]   sixd;
  logic [MAG_W-1:0]   mag;
  logic [1:0]         third_mag;
  logic signed [MAG_W:0] num;
  logic signed [MAG_W:0] off;
  logic signed [MAG_W:0] top;
  logic [2*CH_W-1:0]  sat_prod;

  always_comb begin
    // Two compare-and-select stages find the leading channel.
    b_lt_g  = (pix.blue < pix.green);
    px      = b_lt_g ? pix.green : pix.blue;
    py      = b_lt_g ? pix.blue  : pix.green;
    px_lt_r = (px < pix.red);
    qx      = px_lt_r ? pix.red : px;
    qw      = px_lt_r ? px : pix.red;
    lo      = (qw < py) ? qw : py;
    d       = qx - lo;
    d_ext   = MAG_W'(d);
    sixd    = (d_ext << 2) + (d_ext << 1);
    num     = $signed({1'b0, MAG_W'(qw)}) - $signed({1'b0, MAG_W'(py)});

    // Offset in thirds of a turn, scaled by 2d.
    case ({b_lt_g, px_lt_r})
      2'b11: begin
        off = '0;
        third_mag = 2'd0;
      end
      2'b01: begin
        off = -$signed({1'b0, sixd});
        third_mag = 2'd3;
      end
      2'b10: begin
        off = -$signed({1'b0, d_ext << 1});
        third_mag = 2'd1;
      end
      default: begin
        off = $signed({1'b0, d_ext << 2});
        third_mag = 2'd2;
      end
    endcase

    top = off + num;
    mag = top[MAG_W] ? MAG_W'(-top) : top[MAG_W-1:0];

    data_nxt = '0;
    if (d == '0) begin
      data_nxt.hue_rem = {MAG_W'(third_mag), {HUE_W{1'b0}}};
      data_nxt.hue_div = {MAG_W'(3), {HUE_W{1'b0}}};
    end else begin
      data_nxt.hue_rem = {mag, {HUE_W{1'b0}}};
      data_nxt.hue_div = {sixd, {HUE_W{1'b0}}};
    end

    // d * (2^CH_W - 1); a black pixel divides zero by one.
    sat_prod = {d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, d};
    sat_den  = (qx == '0) ? CH_W'(1) : qx;
    data_nxt.sat_rem    = REM_W'(sat_prod);
    data_nxt.sat_div    = {MAG_W'(sat_den), {HUE_W{1'b0}}};
    data_nxt.brightness = qx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: design/rhc_checker.sv
`include "rgb_to_hsv_converter_macros.svh"

module rhc_checker import rhc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input rhc_pixel_t in_pixel,
  input logic       out_valid,
  input rhc_hsv_t   out_result
);

  logic in_beat;
  logic in_grey;
  logic grey_ok;
  logic black_out;

  assign in_beat   = start && !busy;
  assign in_grey   = start && (in_pixel.red == in_pixel.green)
                     && (in_pixel.green == in_pixel.blue);
  assign grey_ok   = (out_result.saturation == '0)
                     && (out_result.hue == HUE_W'(HUE_GREY));
  assign black_out = out_valid && (out_result.brightness == '0);

  `RHC_ASSERT(a_never_busy, !busy, "busy raised")
  `RHC_ASSERT_IMP(a_beat_out, in_beat, ##LATENCY out_valid, "result beat missing")
  `RHC_ASSERT_IMP(a_no_extra, !in_beat, ##LATENCY !out_valid, "spurious result beat")
  `RHC_ASSERT_IMP(a_black_sat, black_out, out_result.saturation == '0, "black with saturation")
  `RHC_ASSERT_IMP(a_grey, in_grey, ##LATENCY grey_ok, "grey pixel result wrong")

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);
